// File: hdl/header_length_checksum_deframer_unit_defines.svh
`ifndef HEADER_LENGTH_CHECKSUM_DEFRAMER_UNIT_DEFINES_SVH
`define HEADER_LENGTH_CHECKSUM_DEFRAMER_UNIT_DEFINES_SVH

// Clocked assertion that is switched off while reset is asserted.
`define HLCD_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Clocked assertion that is also checked during reset.
`define HLCD_ASSERT_RST(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// File: hdl/hlcd_pkg.sv
`default_nettype none

package hlcd_pkg;

    localparam logic [7:0]  HDR_FIRST       = 8'hAA;
    localparam logic [7:0]  HDR_SECOND      = 8'h55;
    localparam int          MAX_PAYLOAD_DEF = 32;
    localparam logic [31:0] TIMEOUT_RESET   = 32'd1000;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic acc;           // a word is accepted on the input side
        logic len_load;      // take the length byte, start a new frame
        logic fill_write;    // store a payload byte and add it to the sum
        logic replay_start;  // rewind the replay counter
        logic load;          // read one stored byte into the output register
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic timeout_hit;
        logic is_first;
        logic is_second;
        logic len_over;
        logic len_zero;
        logic fill_done;
        logic sum_match;
        logic replay_last;
        logic slot_free;
    } t_stat;

endpackage

`default_nettype wire

// File: hdl/header_length_checksum_deframer_unit.sv
// Parsing: one input word per cycle while a frame is being received.
// A matching checksum word starts a replay: the controller enters its replay state,
// which then loads one result per cycle into the output register as the sink takes them.
// Input is held off for the whole replay, including any sink stalls.
// Reset (synchronous, active low) returns the parser to header hunting, clears the
// output valid and sets timeout_ms to 1000; the payload memory is not cleared.
`default_nettype none

module header_length_checksum_deframer_unit #(
    parameter int MAX_PAYLOAD = hlcd_pkg::MAX_PAYLOAD_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [31:0] i_cfg_data,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // [7:0] rx_byte, [39:8] time_ms
    input  wire logic [39:0] s_axis_tdata,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // [7:0] payload_byte, [12:8] byte_position, [18:13] frame_length, [23:19] zero
    output logic [23:0]      m_axis_tdata,
    // [0] empty_frame
    output logic             m_axis_tuser,
    output logic             m_axis_tlast
);

    hlcd_pkg::t_cmd  cmd;
    hlcd_pkg::t_stat stat;
    logic [7:0]      payload_byte;
    logic [4:0]      byte_position;
    logic [5:0]      frame_length;

    assign o_cfg_ready = 1'b1;

    hlcd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    hlcd_datapath #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg_valid),
        .i_cfg_data      (i_cfg_data),
        .i_rx_byte       (s_axis_tdata[7:0]),
        .i_time_ms       (s_axis_tdata[39:8]),
        .i_cmd           (cmd),
        .o_stat          (stat),
        .i_out_ready     (m_axis_tready),
        .o_out_valid     (m_axis_tvalid),
        .o_payload_byte  (payload_byte),
        .o_byte_position (byte_position),
        .o_frame_length  (frame_length),
        .o_empty_frame   (m_axis_tuser),
        .o_last_of_frame (m_axis_tlast)
    );

    assign m_axis_tdata = {5'd0, frame_length, byte_position, payload_byte};

endmodule

`default_nettype wire

// File: hdl/hlcd_ctrl.sv
`default_nettype none

module hlcd_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_ready,
    input  hlcd_pkg::t_stat    i_stat,
    output hlcd_pkg::t_cmd     o_cmd
);

    typedef enum logic [2:0] {
        S_HUNT,
        S_HDR2,
        S_LEN,
        S_DATA,
        S_CHECK,
        S_REPLAY
    } t_state;

    t_state r_state;
    t_state n_state;
    t_state eff_state;
    logic   acc;

    assign o_in_ready = (r_state != S_REPLAY);
    assign acc        = i_in_valid && o_in_ready;

    // A long gap between words drops whatever frame was in progress.
    assign eff_state = i_stat.timeout_hit ? S_HUNT : r_state;

    always_comb begin
        n_state            = r_state;
        o_cmd              = '0;
        o_cmd.acc          = acc;
        if (r_state == S_REPLAY) begin
            if (i_stat.slot_free) begin
                o_cmd.load = 1'b1;
                if (i_stat.replay_last) begin
                    n_state = S_HUNT;
                end
            end
        end else if (acc) begin
            case (eff_state)
                S_HDR2: begin
                    n_state = i_stat.is_second ? S_LEN : S_HUNT;
                end
                S_LEN: begin
                    if (i_stat.len_over) begin
                        n_state = S_HUNT;
                    end else begin
                        o_cmd.len_load = 1'b1;
                        n_state        = i_stat.len_zero ? S_CHECK : S_DATA;
                    end
                end
                S_DATA: begin
                    o_cmd.fill_write = 1'b1;
                    if (i_stat.fill_done) begin
                        n_state = S_CHECK;
                    end
                end
                S_CHECK: begin
                    if (i_stat.sum_match) begin
                        o_cmd.replay_start = 1'b1;
                        n_state            = S_REPLAY;
                    end else begin
                        n_state = S_HUNT;
                    end
                end
                default: begin
                    n_state = i_stat.is_first ? S_HDR2 : S_HUNT;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_HUNT;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

// File: hdl/hlcd_datapath.sv
`default_nettype none

module hlcd_datapath #(
    parameter int MAX_PAYLOAD = hlcd_pkg::MAX_PAYLOAD_DEF
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_cfg_valid,
    input  wire logic [31:0]   i_cfg_data,
    input  wire logic [7:0]    i_rx_byte,
    input  wire logic [31:0]   i_time_ms,
    input  hlcd_pkg::t_cmd     i_cmd,
    output hlcd_pkg::t_stat    o_stat,
    input  wire logic          i_out_ready,
    output logic               o_out_valid,
    output logic [7:0]         o_payload_byte,
    output logic [4:0]         o_byte_position,
    output logic [5:0]         o_frame_length,
    output logic               o_empty_frame,
    output logic               o_last_of_frame
);

    localparam int LW = $clog2(MAX_PAYLOAD + 1);
    localparam int AW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;

    logic [31:0]   r_timeout;
    logic [31:0]   r_prev_time;
    logic [31:0]   gap;
    logic [LW-1:0] r_len;
    logic [LW-1:0] r_fill;
    logic [LW-1:0] r_k;
    logic [7:0]    r_sum;
    logic [7:0]    mem [MAX_PAYLOAD];
    logic [7:0]    r_rd;
    logic [4:0]    r_pos;
    logic [5:0]    r_flen;
    logic          r_last;
    logic          r_empty;
    logic          r_out_valid;
    logic [LW:0]   fill_next;
    logic [LW:0]   k_next;
    logic [7:0]    k8;
    logic [7:0]    len8;

    assign gap       = i_time_ms - r_prev_time;
    assign fill_next = {1'b0, r_fill} + 1'b1;
    assign k_next    = {1'b0, r_k} + 1'b1;
    assign k8        = 8'(r_k);
    assign len8      = 8'(r_len);

    always_comb begin
        o_stat             = '0;
        o_stat.timeout_hit = (gap > r_timeout);
        o_stat.is_first    = (i_rx_byte == hlcd_pkg::HDR_FIRST);
        o_stat.is_second   = (i_rx_byte == hlcd_pkg::HDR_SECOND);
        o_stat.len_over    = (i_rx_byte > 8'(MAX_PAYLOAD));
        o_stat.len_zero    = (i_rx_byte == 8'd0);
        o_stat.fill_done   = (fill_next >= {1'b0, r_len});
        o_stat.sum_match   = (r_sum == i_rx_byte);
        o_stat.replay_last = (r_len == '0) || (k_next == {1'b0, r_len});
        o_stat.slot_free   = !r_out_valid || i_out_ready;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout   <= hlcd_pkg::TIMEOUT_RESET;
            r_prev_time <= '0;
            r_len       <= '0;
            r_fill      <= '0;
            r_sum       <= '0;
            r_k         <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_timeout <= i_cfg_data;
            end
            if (i_cmd.acc) begin
                r_prev_time <= i_time_ms;
            end
            if (i_cmd.len_load) begin
                r_len  <= LW'(i_rx_byte);
                r_fill <= '0;
                r_sum  <= i_rx_byte;
            end else if (i_cmd.fill_write) begin
                r_fill <= fill_next[LW-1:0];
                r_sum  <= r_sum + i_rx_byte;
            end
            if (i_cmd.replay_start) begin
                r_k <= '0;
            end else if (i_cmd.load) begin
                r_k <= k_next[LW-1:0];
            end
            if (i_cmd.load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload store; the read port doubles as the output data register.
    // The frame length is captured with each word, since a new length byte
    // may arrive while the last word of the previous frame is still waiting.
    always_ff @(posedge i_clk) begin
        if (i_cmd.fill_write) begin
            mem[r_fill[AW-1:0]] <= i_rx_byte;
        end
        if (i_cmd.load) begin
            r_rd    <= mem[r_k[AW-1:0]];
            r_pos   <= k8[4:0];
            r_flen  <= len8[5:0];
            r_last  <= o_stat.replay_last;
            r_empty <= (r_len == '0);
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_payload_byte  = r_empty ? 8'd0 : r_rd;
    assign o_byte_position = r_pos;
    assign o_frame_length  = r_flen;
    assign o_empty_frame   = r_empty;
    assign o_last_of_frame = r_last;

endmodule

`default_nettype wire

// File: hdl/hlcd_checker.sv
`default_nettype none
`include "header_length_checksum_deframer_unit_defines.svh"

module hlcd_checker (
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic s_axis_tvalid,
    input wire logic s_axis_tready,
    input wire logic m_axis_tvalid,
    input wire logic m_axis_tready,
    input wire logic m_axis_tuser,
    input wire logic m_axis_tlast
);

    // A result word that is not taken stays on offer.
    `HLCD_ASSERT(a_out_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid, "result dropped while stalled")

    // Input is only held off after a word was accepted, namely the checksum word.
    `HLCD_ASSERT(a_ready_fall, $fell(s_axis_tready) |-> $past(s_axis_tvalid && s_axis_tready), "input stalled without a checksum word")

    // While a frame is being replayed the input side stays closed.
    `HLCD_ASSERT(a_replay_closed, m_axis_tvalid && !m_axis_tlast |-> !s_axis_tready, "input open in the middle of a frame")

    // An empty frame marker is always the only and last word of its run.
    `HLCD_ASSERT(a_empty_last, m_axis_tvalid && m_axis_tuser |-> m_axis_tlast, "empty frame marker without last")

    // Reset removes any pending result.
    `HLCD_ASSERT_RST(a_reset_clear, !i_rst_n |=> !m_axis_tvalid, "result valid after reset")

endmodule

bind header_length_checksum_deframer_unit hlcd_checker u_hlcd_checker (.*);

`default_nettype wire

// File: bench/header_length_checksum_deframer_unit_tb.sv
`default_nettype none

module header_length_checksum_deframer_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_LEN       = hlcd_pkg::MAX_PAYLOAD_DEF;
    localparam int SETTLE_CYCLES = 40;
    localparam int IDLE_LIMIT    = 2000;

    typedef enum logic [2:0] {
        PH_HUNT,
        PH_SECOND,
        PH_LEN,
        PH_FILL,
        PH_SUM
    } t_frame_phase;

    typedef struct {
        logic [7:0] data;
        logic [4:0] pos;
        logic [5:0] len;
        logic       empty;
        logic       last;
    } t_frame_word;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [31:0] i_cfg_data;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;
    logic        m_axis_tuser;
    logic        m_axis_tlast;

    // Parser state tracked alongside the block.
    logic [31:0]  gap_limit;
    t_frame_phase rx_phase;
    int           frame_len;
    int           fill_cnt;
    logic [7:0]   byte_sum;
    logic [7:0]   stored_payload[MAX_LEN];
    logic [31:0]  last_stamp;

    t_frame_word  expected_payload[$];
    logic [7:0]   outgoing_frame[$];
    logic [31:0]  clock_ms;
    bit           steady = 1'b0;
    bit           next_stale;
    int           words_sent;
    int           fault_count;
    int           stuck_cycles = 0;

    header_length_checksum_deframer_unit DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_data   (i_cfg_data),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser),
        .m_axis_tlast (m_axis_tlast)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    always @(negedge i_clk) begin
        m_axis_tready <= steady || ($urandom_range(99, 0) >= 8);
    end

    task automatic clear_parser();
        rx_phase  = PH_HUNT;
        frame_len = 0;
        fill_cnt  = 0;
        byte_sum  = 8'h00;
    endtask

    // Advances the tracked parser by one accepted byte and queues any payload it releases.
    task automatic parse_word(input logic [7:0] b, input logic [31:0] stamp);
        t_frame_word w;
        if (stamp - last_stamp > gap_limit) begin
            clear_parser();
        end
        last_stamp = stamp;
        case (rx_phase)
            PH_SECOND: begin
                rx_phase = (b == hlcd_pkg::HDR_SECOND) ? PH_LEN : PH_HUNT;
            end
            PH_LEN: begin
                if (b > MAX_LEN) begin
                    clear_parser();
                end else begin
                    frame_len = b;
                    fill_cnt  = 0;
                    byte_sum  = b;
                    rx_phase  = (b == 8'd0) ? PH_SUM : PH_FILL;
                end
            end
            PH_FILL: begin
                if (fill_cnt < MAX_LEN) begin
                    stored_payload[fill_cnt] = b;
                end
                fill_cnt++;
                byte_sum = byte_sum + b;
                if (fill_cnt >= frame_len) begin
                    rx_phase = PH_SUM;
                end
            end
            PH_SUM: begin
                if (byte_sum == b) begin
                    rx_phase = PH_HUNT;
                    if (frame_len == 0) begin
                        w = '{data: 8'h00, pos: 5'd0, len: 6'd0, empty: 1'b1, last: 1'b1};
                        expected_payload.push_back(w);
                    end else begin
                        for (int k = 0; k < frame_len; k++) begin
                            w.data  = stored_payload[k];
                            w.pos   = k[4:0];
                            w.len   = frame_len[5:0];
                            w.empty = 1'b0;
                            w.last  = (k + 1 == frame_len);
                            expected_payload.push_back(w);
                        end
                    end
                end else begin
                    clear_parser();
                end
            end
            default: begin
                rx_phase = (b == hlcd_pkg::HDR_FIRST) ? PH_SECOND : PH_HUNT;
            end
        endcase
    endtask

    task automatic compare_field(input string name, input int unsigned want,
                                 input int unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            fault_count++;
        end
    endtask

    always @(posedge i_clk) begin : result_check
        t_frame_word want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_payload.size() == 0) begin
                $error("result word with nothing expected: payload_byte %0h",
                       m_axis_tdata[7:0]);
                fault_count++;
            end else begin
                want = expected_payload.pop_front();
                compare_field("payload_byte", want.data, m_axis_tdata[7:0]);
                compare_field("byte_position", want.pos, m_axis_tdata[12:8]);
                compare_field("frame_length", want.len, m_axis_tdata[18:13]);
                compare_field("empty_frame", want.empty, m_axis_tuser);
                compare_field("last_of_frame", want.last, m_axis_tlast);
            end
        end
    end

    // Ends the run when neither side nor the register port moves for too long.
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (i_cfg_valid && o_cfg_ready)) begin
            stuck_cycles <= 0;
        end else begin
            stuck_cycles <= stuck_cycles + 1;
        end
        if (stuck_cycles >= IDLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    function automatic logic [31:0] quiet_gap();
        logic [31:0] hi;
        hi = (gap_limit < 32'd60) ? gap_limit : 32'd60;
        if ($urandom_range(9, 0) == 0) begin
            return $urandom_range(gap_limit, 0);
        end
        return $urandom_range(hi, 0);
    endfunction

    function automatic logic [31:0] stale_gap();
        logic [31:0] headroom;
        if (gap_limit == 32'hFFFF_FFFF) begin
            return quiet_gap();
        end
        headroom = ~gap_limit;
        return gap_limit + 32'd1 + ($urandom % headroom);
    endfunction

    function automatic logic [31:0] pick_gap();
        if (next_stale) begin
            next_stale = 1'b0;
            return stale_gap();
        end
        return quiet_gap();
    endfunction

    // Called and returns at a falling edge with the input valid low.
    task automatic send_word(input logic [7:0] b, input logic [31:0] gap);
        clock_ms = clock_ms + gap;
        while (!steady && $urandom_range(99, 0) < 8) begin
            @(negedge i_clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = {clock_ms, b};
        do @(posedge i_clk); while (!s_axis_tready);
        parse_word(b, clock_ms);
        words_sent++;
        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
    endtask

    // A negative pattern gives random payload bytes.
    task automatic build_frame(input int len, input int pattern, input bit bad_sum);
        logic [7:0] chk;
        logic [7:0] b;
        outgoing_frame.delete();
        outgoing_frame.push_back(hlcd_pkg::HDR_FIRST);
        outgoing_frame.push_back(hlcd_pkg::HDR_SECOND);
        outgoing_frame.push_back(len[7:0]);
        if (len <= MAX_LEN) begin
            chk = len[7:0];
            for (int i = 0; i < len; i++) begin
                b = (pattern < 0) ? 8'($urandom) : pattern[7:0];
                chk = chk + b;
                outgoing_frame.push_back(b);
            end
            outgoing_frame.push_back(bad_sum ? chk ^ (8'h01 << $urandom_range(7, 0)) : chk);
        end
    endtask

    // Sends the first cut words of a frame, or all of them when cut is negative.
    task automatic send_frame(input int len, input int pattern, input bit bad_sum,
                              input int cut);
        int n;
        build_frame(len, pattern, bad_sum);
        n = (cut < 0 || cut > outgoing_frame.size()) ? outgoing_frame.size() : cut;
        for (int i = 0; i < n; i++) begin
            send_word(outgoing_frame[i], pick_gap());
        end
    endtask

    task automatic send_timed_frame(input int len, input logic [31:0] gap, input int late_at);
        build_frame(len, -1, 1'b0);
        for (int i = 0; i < outgoing_frame.size(); i++) begin
            send_word(outgoing_frame[i], (i == late_at) ? gap + 32'd1 : gap);
        end
    endtask

    task automatic wait_for_results();
        while (expected_payload.size() != 0) begin
            @(negedge i_clk);
        end
    endtask

    task automatic settle_block();
        wait_for_results();
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_timeout(input logic [31:0] value);
        settle_block();
        i_cfg_valid = 1'b1;
        i_cfg_data  = value;
        do @(posedge i_clk); while (!o_cfg_ready);
        gap_limit = value;
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    task automatic test_header_cases();
        send_frame(0, -1, 1'b0, -1);
        send_frame(1, 8'hFF, 1'b0, -1);
        // A repeated first header byte is consumed as a bad second byte.
        send_word(hlcd_pkg::HDR_FIRST, quiet_gap());
        send_word(hlcd_pkg::HDR_FIRST, quiet_gap());
        send_word(hlcd_pkg::HDR_SECOND, quiet_gap());
        send_word(hlcd_pkg::HDR_FIRST, quiet_gap());
        send_word(8'h12, quiet_gap());
        send_frame(MAX_LEN + 1, -1, 1'b0, -1);
        send_frame(255, -1, 1'b0, -1);
        send_frame(2, -1, 1'b1, -1);
        send_frame(0, -1, 1'b1, -1);
    endtask

    task automatic test_timeout_edges();
        write_timeout(hlcd_pkg::TIMEOUT_RESET);
        send_timed_frame(1, hlcd_pkg::TIMEOUT_RESET, -1);
        send_timed_frame(1, hlcd_pkg::TIMEOUT_RESET, 3);
        write_timeout(32'd0);
        send_timed_frame(1, 32'd0, -1);
        send_timed_frame(1, 32'd0, 4);
        write_timeout(32'hFFFF_FFFF);
        send_timed_frame(1, 32'hFFFF_FFFF, -1);
        // Jump just short of the wrap, then run a frame across it with small gaps.
        write_timeout(hlcd_pkg::TIMEOUT_RESET);
        send_word(8'h00, 32'hFFFF_FFFC - clock_ms);
        send_timed_frame(2, 32'd1, -1);
    endtask

    // A full-size frame with neither side idling.
    task automatic test_long_frames();
        write_timeout($urandom_range(5000, 100));
        steady = 1'b1;
        send_frame(MAX_LEN, -1, 1'b0, -1);
        wait_for_results();
        steady = 1'b0;
    endtask

    task automatic test_drained_sender();
        repeat (2) begin
            send_frame($urandom_range(3, 0), -1, 1'b0, -1);
            wait_for_results();
        end
    endtask

    task automatic test_random_traffic(input int word_budget, input bit no_gaps);
        int stop_at;
        int kind;
        int len;
        steady  = no_gaps;
        stop_at = words_sent + word_budget;
        while (words_sent < stop_at) begin
            kind = $urandom_range(99, 0);
            len  = ($urandom_range(9, 0) == 0) ? $urandom_range(MAX_LEN, 9)
                                               : $urandom_range(8, 0);
            if (kind < 70) begin
                send_frame(len, -1, 1'b0, -1);
            end else if (kind < 78) begin
                send_frame(len, -1, 1'b1, -1);
            end else if (kind < 84) begin
                send_frame($urandom_range(255, MAX_LEN + 1), -1, 1'b0, -1);
            end else if (kind < 90) begin
                // Frame broken off before its checksum, then a long silence unless the timeout is at its maximum.
                send_frame(len + 1, -1, 1'b0, $urandom_range(len + 4, 1));
                next_stale = 1'b1;
            end else if (kind < 95) begin
                repeat ($urandom_range(3, 1)) begin
                    send_word($urandom_range(1, 0) ? hlcd_pkg::HDR_FIRST : 8'($urandom),
                              ($urandom_range(4, 0) == 0) ? $urandom : quiet_gap());
                end
            end else begin
                send_frame(len, -1, 1'b0, -1);
                wait_for_results();
            end
        end
        steady = 1'b0;
    endtask

    initial begin
        i_rst_n       = 1'b0;
        i_cfg_valid   = 1'b0;
        i_cfg_data    = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        next_stale    = 1'b0;
        clock_ms      = '0;
        words_sent    = 0;
        fault_count   = 0;
        gap_limit     = hlcd_pkg::TIMEOUT_RESET;
        last_stamp    = '0;
        clear_parser();
        repeat (7) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_header_cases();
        test_timeout_edges();
        test_long_frames();
        test_drained_sender();

        write_timeout(hlcd_pkg::TIMEOUT_RESET);
        test_random_traffic(6, 1'b0);
        write_timeout(32'hFFFF_FFFF);
        test_random_traffic(4, 1'b1);
        write_timeout($urandom_range(200, 1));
        test_random_traffic(4, 1'b0);

        settle_block();
        if (fault_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

`default_nettype wire

// File: sim.f
+incdir+hdl
hdl/hlcd_pkg.sv
hdl/hlcd_ctrl.sv
hdl/hlcd_datapath.sv
hdl/header_length_checksum_deframer_unit.sv
hdl/hlcd_checker.sv
bench/header_length_checksum_deframer_unit_tb.sv
